### rtl/prv_pkg.sv
// Shared types, constants and the CRC helper for the palette record validator.
`timescale 1ns / 1ps

package prv_pkg;

    // Sizes of the record and its parts, in bytes.
    localparam logic [7:0] HDR_LEN = 8'd6;
    localparam logic [7:0] ENT_LEN = 8'd4;
    localparam logic [7:0] CRC_LEN = 8'd4;
    localparam logic [6:0] POS_MAX = 7'd127;

    // Header magic bytes.
    localparam logic [7:0] MAGIC_P = 8'h50;
    localparam logic [7:0] MAGIC_L = 8'h4C;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Default number of entries a record may carry.
    localparam int MAX_ENTRIES_DEF = 8;

    // Width of the configuration register index.
    localparam int CFG_AW = 3;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_VALID   = 4'd0,
        ST_LENGTH  = 4'd1,
        ST_MAGIC   = 4'd2,
        ST_VERSION = 4'd3,
        ST_MODE    = 4'd4,
        ST_COUNT   = 4'd5,
        ST_FLAGS   = 4'd6,
        ST_CRC     = 4'd7,
        ST_DUP     = 4'd8,
        ST_ROLE    = 4'd9
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        CFG_SCHEMA_VERSION = 3'd0,
        CFG_EXPECTED_MODE  = 3'd1,
        CFG_MODE_MIN       = 3'd2,
        CFG_MODE_MAX       = 3'd3,
        CFG_ALLOWED_ROLES  = 3'd4,
        CFG_ROLE_COUNT     = 3'd5
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [1:0] {
        S_RECV,
        S_DECIDE,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic byte_en;
        logic load_status;
        logic start_emit;
        logic load_entry;
        logic clear;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic record_ok;
        logic out_free;
        logic emit_final;
    } t_dp_stat;

    // One byte step of the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

### rtl/palette_record_validator.sv
// Top level of the palette record validator: controller plus datapath.
`timescale 1ns / 1ps
//
// A stored palette record enters on the slave stream one byte per transaction,
// with tlast on its final byte. The record is a six-byte header, one four-byte
// entry per declared count and a little-endian CRC-32 over the preceding bytes.
// Bytes are taken one per cycle while a record is being received; the CRC is
// folded in byte by byte as they pass. After the last byte the block chooses
// the record status in its decide state, during which tready is low. A bad
// record then gives one result carrying its status, registered from the decide
// state once the output register is free. A good one gives one result per
// entry, one per cycle unless the master side stalls, registered from the emit
// state that follows, the last with tlast set. The output register lets the
// next record start while the final result waits; a stall on the master side
// holds the results and then the input. Configuration is to be written through
// the plain write port only while no record is in flight; the block itself
// does not enforce this. Reset restores the register defaults and clears all
// record state; the entry store is not cleared, as it is only read once filled.
//
module palette_record_validator #(
    parameter int MAX_ENTRIES = prv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [prv_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [63:0]                 i_cfg_wdata,
    // Record bytes in.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] data_byte
    input  logic                        i_s_axis_tlast,   // last_byte
    // Results out.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [3:0] status, [6:4] entry_index, [14:7] role_code, [22:15] red,
    // [30:23] green, [38:31] blue, [39] zero
    output logic [39:0]                 o_m_axis_tdata,
    output logic                        o_m_axis_tlast    // final_result
);
    import prv_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // Sequencing of receive, decide and emit phases.
    prv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_axis_tvalid),
        .i_byte_last  (i_s_axis_tlast),
        .i_stat       (stat),
        .o_byte_ready (o_s_axis_tready),
        .o_cmd        (cmd)
    );

    // Checks, CRC, entry storage and the result register.
    prv_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_s_axis_tdata),
        .i_cmd       (cmd),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

### rtl/prv_ctrl.sv
// Controller state machine: receive bytes, decide the record status, emit entries.
`timescale 1ns / 1ps

module prv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_byte_valid,
    input  logic                i_byte_last,
    input  prv_pkg::t_dp_stat   i_stat,
    output logic                o_byte_ready,
    output prv_pkg::t_ctrl_cmd  o_cmd
);
    import prv_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RECV: begin
                if (i_byte_valid && i_byte_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.record_ok) begin
                    n_state = S_EMIT;
                end else if (i_stat.out_free) begin
                    n_state = S_RECV;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_final) begin
                    n_state = S_RECV;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    // Outputs.
    always_comb begin
        o_byte_ready = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_RECV: begin
                o_byte_ready  = 1'b1;
                o_cmd.byte_en = i_byte_valid;
            end
            S_DECIDE: begin
                o_cmd.load_status = !i_stat.record_ok && i_stat.out_free;
                o_cmd.start_emit  = i_stat.record_ok;
                o_cmd.clear       = i_stat.record_ok || i_stat.out_free;
            end
            S_EMIT: begin
                o_cmd.load_entry = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/prv_dpath.sv
// Datapath: header checks, CRC, entry store, status selection and the output register.
`timescale 1ns / 1ps

module prv_dpath #(
    parameter int MAX_ENTRIES = prv_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [prv_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [63:0]                 i_cfg_wdata,
    input  logic [7:0]                  i_byte,
    input  prv_pkg::t_ctrl_cmd          i_cmd,
    input  logic                        i_out_ready,
    output prv_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    output logic [39:0]                 o_out_data,
    output logic                        o_out_last
);
    import prv_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_MIN = 14;
    localparam int LEN_MAX = 6 + 4 * MAX_ENTRIES + 4;

    // Configuration registers.
    logic [7:0]  r_schema_version;
    logic [7:0]  r_expected_mode;
    logic [7:0]  r_mode_min;
    logic [7:0]  r_mode_max;
    logic [63:0] r_allowed_roles;
    logic [3:0]  r_role_count;

    // Per-record state.
    logic [6:0]  r_pos;
    logic [31:0] r_crc;
    logic [31:0] r_received_crc;
    logic [7:0]  r_count;
    t_status     r_header_error;
    t_status     r_entry_error;
    logic [7:0]  r_roles_seen;
    logic [31:0] r_entry_store [MAX_ENTRIES];

    // Emit sequencing and output register.
    logic [IDX_W-1:0] r_emit_idx;
    logic [IDX_W-1:0] r_emit_last;
    logic             r_out_valid;
    logic [39:0]      r_out_data;
    logic             r_out_last;

    // Per-byte decode.
    logic [7:0]  decl;
    logic [10:0] p_ext;
    logic [10:0] crc_off;
    logic [10:0] crc_rel;
    logic        in_crc;
    logic        in_rx;
    logic [6:0]  ent_off;
    logic [4:0]  ent_idx;
    logic [1:0]  ent_part;
    logic        ent_in;
    logic [3:0]  role_limit;
    logic [2:0]  role_slot;
    logic        role_found;
    t_status     hdr_code;

    // Record decision.
    logic [10:0] exp_len;
    t_status     rec_status;
    logic        out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_schema_version <= 8'd1;
            r_expected_mode  <= 8'd1;
            r_mode_min       <= 8'd1;
            r_mode_max       <= 8'd3;
            r_allowed_roles  <= 64'd0;
            r_role_count     <= 4'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SCHEMA_VERSION: r_schema_version <= i_cfg_wdata[7:0];
                CFG_EXPECTED_MODE:  r_expected_mode  <= i_cfg_wdata[7:0];
                CFG_MODE_MIN:       r_mode_min       <= i_cfg_wdata[7:0];
                CFG_MODE_MAX:       r_mode_max       <= i_cfg_wdata[7:0];
                CFG_ALLOWED_ROLES:  r_allowed_roles  <= i_cfg_wdata;
                CFG_ROLE_COUNT:     r_role_count     <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Byte position decode: CRC span, trailing CRC field and entry slot.
    always_comb begin
        decl     = (r_pos == 7'd4) ? i_byte : r_count;
        p_ext    = {4'd0, r_pos};
        crc_off  = 11'(HDR_LEN) + {1'b0, decl, 2'b00};
        crc_rel  = p_ext - crc_off;
        in_crc   = p_ext < crc_off;
        in_rx    = !in_crc && (p_ext < crc_off + 11'(CRC_LEN));
        ent_off  = r_pos - 7'(HDR_LEN);
        ent_idx  = ent_off[6:2];
        ent_part = ent_off[1:0];
        ent_in   = in_crc && (r_pos >= 7'(HDR_LEN)) && (ent_idx < 5'(MAX_ENTRIES));
    end

    // Role lookup: the first matching slot among the allowed codes wins.
    always_comb begin
        role_limit = (r_role_count > 4'd8) ? 4'd8 : r_role_count;
        role_slot  = 3'd0;
        role_found = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if ((4'(k) < role_limit) && (r_allowed_roles[8*k +: 8] == i_byte)) begin
                role_slot  = 3'(k);
                role_found = 1'b1;
            end
        end
    end

    // Header field checks for the current byte.
    always_comb begin
        hdr_code = ST_VALID;
        case (r_pos)
            7'd0: if (i_byte != MAGIC_P) hdr_code = ST_MAGIC;
            7'd1: if (i_byte != MAGIC_L) hdr_code = ST_MAGIC;
            7'd2: if (i_byte != r_schema_version) hdr_code = ST_VERSION;
            7'd3: begin
                if (i_byte != r_expected_mode || i_byte < r_mode_min || i_byte > r_mode_max) begin
                    hdr_code = ST_MODE;
                end
            end
            7'd4: begin
                if (i_byte == 8'd0 || i_byte > {4'd0, role_limit}
                        || i_byte > 8'(MAX_ENTRIES)) begin
                    hdr_code = ST_COUNT;
                end
            end
            7'd5: if (i_byte != 8'd0) hdr_code = ST_FLAGS;
            default: hdr_code = ST_VALID;
        endcase
    end

    // Per-record state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos          <= '0;
            r_crc          <= CRC_INIT;
            r_received_crc <= '0;
            r_count        <= '0;
            r_header_error <= ST_VALID;
            r_entry_error  <= ST_VALID;
            r_roles_seen   <= '0;
        end else if (i_cmd.byte_en) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + 7'd1;
            end
            if (r_pos == 7'd4) begin
                r_count <= i_byte;
            end
            if (r_header_error == ST_VALID && hdr_code != ST_VALID) begin
                r_header_error <= hdr_code;
            end
            if (in_crc) begin
                r_crc <= crc_byte(r_crc, i_byte);
            end else if (in_rx) begin
                r_received_crc[8*crc_rel[1:0] +: 8] <= i_byte;
            end
            // Role checks on the first byte of each entry.
            if (ent_in && ent_part == 2'd0) begin
                if (!role_found) begin
                    if (r_entry_error == ST_VALID) r_entry_error <= ST_ROLE;
                end else if (r_roles_seen[role_slot]) begin
                    if (r_entry_error == ST_VALID) r_entry_error <= ST_DUP;
                end else begin
                    r_roles_seen[role_slot] <= 1'b1;
                end
            end
        end
    end

    // Entry store, written one byte lane at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_en && ent_in) begin
            r_entry_store[ent_idx[IDX_W-1:0]][8*ent_part +: 8] <= i_byte;
        end
    end

    // Status of a finished record, in priority order.
    always_comb begin
        exp_len = 11'(HDR_LEN + CRC_LEN) + {1'b0, r_count, 2'b00};
        if (r_pos < 7'(LEN_MIN) || r_pos > 7'(LEN_MAX)) begin
            rec_status = ST_LENGTH;
        end else if (r_header_error != ST_VALID) begin
            rec_status = r_header_error;
        end else if (p_ext != exp_len) begin
            rec_status = ST_LENGTH;
        end else if (~r_crc != r_received_crc) begin
            rec_status = ST_CRC;
        end else begin
            rec_status = r_entry_error;
        end
    end

    assign out_free          = !r_out_valid || i_out_ready;
    assign o_stat.record_ok  = (rec_status == ST_VALID);
    assign o_stat.out_free   = out_free;
    assign o_stat.emit_final = (r_emit_idx == r_emit_last);

    // Emit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_idx  <= '0;
            r_emit_last <= '0;
        end else if (i_cmd.start_emit) begin
            r_emit_idx  <= '0;
            r_emit_last <= r_count[IDX_W-1:0] - IDX_W'(1);
        end else if (i_cmd.load_entry) begin
            r_emit_idx <= r_emit_idx + IDX_W'(1);
        end
    end

    // Output register: holds one transaction until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.load_entry) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_out_data <= {36'd0, rec_status};
            r_out_last <= 1'b1;
        end else if (i_cmd.load_entry) begin
            r_out_data <= {1'b0, r_entry_store[r_emit_idx], 3'(r_emit_idx), ST_VALID};
            r_out_last <= (r_emit_idx == r_emit_last);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule
